// ===== rtl/md5sm_pkg.sv =====
// Shared types, constants and round helpers for the MD5 short-message matcher.
// Has no dependencies; the module and testbench files refer to it by scoped names.
package md5sm_pkg;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  localparam int unsigned NUM_ROUNDS = 64;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_TARGET_A = 3'd0;
  localparam logic [2:0] REG_TARGET_B = 3'd1;
  localparam logic [2:0] REG_TARGET_C = 3'd2;
  localparam logic [2:0] REG_TARGET_D = 3'd3;
  localparam logic [2:0] REG_MSG_LEN  = 3'd4;

  localparam logic [2:0] MSG_LEN_FULL = 3'd4;

  localparam logic [31:0] SINE_K [NUM_ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] SHIFT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } state_t;

  // Message block words that can be nonzero, plus the item's side data.
  typedef struct packed {
    logic [31:0] w0;
    logic        pad1;     // word 1 holds the pad byte (full-length message)
    logic [5:0]  bitlen;   // word 14
    logic [31:0] cand;
    logic        eor;
  } blk_t;

  typedef struct packed {
    logic        match;
    logic [31:0] cand;
    logic        eor;
  } res_t;

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | (d ^ ALL_ONES));
    endcase
    return f;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] g;
    lo = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'd5 * lo + 4'd1;
      2'd2:    g = 4'd3 * lo + 4'd5;
      default: g = 4'd7 * lo;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] round_shift(input logic [5:0] rnd);
    return SHIFT_S[{rnd[5:4], rnd[1:0]}];
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// ===== rtl/md5sm_in_if.sv =====
// Candidate input channel: valid/ready handshake with candidate payload.
// Depends on nothing.
interface md5sm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate_word;
  logic        end_of_range;

  modport source (output valid, output candidate_word, output end_of_range, input ready);
  modport sink   (input valid, input candidate_word, input end_of_range, output ready);
endinterface

// ===== rtl/md5sm_res_if.sv =====
// Result output channel: valid/ready handshake with match flag and echoes.
// Depends on nothing.
interface md5sm_res_if;
  logic        valid;
  logic        ready;
  logic        match;
  logic [31:0] candidate_echo;
  logic        range_done;

  modport source (output valid, output match, output candidate_echo, output range_done,
                  input ready);
  modport sink   (input valid, input match, input candidate_echo, input range_done,
                  output ready);
endinterface

// ===== rtl/md5_short_message_match.sv =====
// Top level of the MD5 short-message matcher: configuration registers, block builder
// and the chain of 64 round cells. Depends on md5sm_pkg, md5sm_in_if, md5sm_res_if,
// md5sm_round_cell and md5sm_out_stage.
//
// Usage:
//   cand_i takes one candidate item per cycle (valid/ready) unless stalled. The low
//   message_length bytes of candidate_word, little-endian, are hashed as a one-block
//   MD5 message. res_o returns one item per candidate, in order: match,
//   candidate_echo and range_done (the candidate's end_of_range).
//   Depth: 66 register stages (64 round cells, one digest finish stage, one output
//   register). The accepting edge loads the first cell. Throughput: one item per cycle
//   while not stalled, set by the one-round-per-cell chain; every cell advances in the
//   same cycle.
//   Stall: when res_o.ready is low the output register holds its item and one more
//   finished item drops into a skid register; only then does cand_i.ready fall and
//   the whole chain hold. Ready returns the cycle after the output drains.
//   Reset: all valid bits clear, targets read zero and message_length reads four.
//   Configuration: APB writes at byte address 4*i (targets A..D, then length); write
//   only while no item is in flight. Lengths above four act as four; zero hashes the
//   empty message.
module md5_short_message_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5sm_in_if.sink    cand_i,
  md5sm_res_if.source res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NR = md5sm_pkg::NUM_ROUNDS;

  md5sm_pkg::state_t target_q;
  logic [2:0]        msg_len_q;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  logic [2:0]        len_eff;
  md5sm_pkg::blk_t   blk_in;
  logic              pipe_en;

  md5sm_pkg::state_t st_w  [NR+1];
  md5sm_pkg::blk_t   blk_w [NR+1];
  logic              vld_w [NR+1];

  // Configuration port: write on the access phase, pready tied high.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      msg_len_q <= md5sm_pkg::MSG_LEN_FULL;
    end else if (cfg_wr) begin
      case (reg_idx)
        md5sm_pkg::REG_TARGET_A: target_q.a <= pwdata;
        md5sm_pkg::REG_TARGET_B: target_q.b <= pwdata;
        md5sm_pkg::REG_TARGET_C: target_q.c <= pwdata;
        md5sm_pkg::REG_TARGET_D: target_q.d <= pwdata;
        md5sm_pkg::REG_MSG_LEN:  msg_len_q  <= pwdata[2:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      md5sm_pkg::REG_TARGET_A: prdata = target_q.a;
      md5sm_pkg::REG_TARGET_B: prdata = target_q.b;
      md5sm_pkg::REG_TARGET_C: prdata = target_q.c;
      md5sm_pkg::REG_TARGET_D: prdata = target_q.d;
      md5sm_pkg::REG_MSG_LEN:  prdata = {29'd0, msg_len_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // Build the padded block: message bytes, the pad byte right after them,
  // and the bit length in word 14. Saturate lengths above four.
  always_comb begin
    len_eff = (msg_len_q > md5sm_pkg::MSG_LEN_FULL) ? md5sm_pkg::MSG_LEN_FULL : msg_len_q;
    blk_in.pad1   = 1'b0;
    blk_in.bitlen = {len_eff, 3'b000};
    blk_in.cand   = cand_i.candidate_word;
    blk_in.eor    = cand_i.end_of_range;
    case (len_eff)
      3'd0:    blk_in.w0 = {24'd0, md5sm_pkg::PAD_BYTE};
      3'd1:    blk_in.w0 = {16'd0, md5sm_pkg::PAD_BYTE, cand_i.candidate_word[7:0]};
      3'd2:    blk_in.w0 = {8'd0, md5sm_pkg::PAD_BYTE, cand_i.candidate_word[15:0]};
      3'd3:    blk_in.w0 = {md5sm_pkg::PAD_BYTE, cand_i.candidate_word[23:0]};
      default: begin
        blk_in.w0   = cand_i.candidate_word;
        blk_in.pad1 = 1'b1;
      end
    endcase
  end

  // Accept whenever the chain advances; it holds only once the skid is full.
  assign cand_i.ready = pipe_en;

  assign st_w[0]  = '{a: md5sm_pkg::IV_A, b: md5sm_pkg::IV_B,
                      c: md5sm_pkg::IV_C, d: md5sm_pkg::IV_D};
  assign blk_w[0] = blk_in;
  assign vld_w[0] = cand_i.valid;

  // Round chain: cell r applies MD5 step r and passes the state to cell r+1.
  for (genvar r = 0; r < NR; r++) begin : g_round
    md5sm_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (6'(r)),
      .en_i    (pipe_en),
      .valid_i (vld_w[r]),
      .st_i    (st_w[r]),
      .blk_i   (blk_w[r]),
      .valid_o (vld_w[r+1]),
      .st_o    (st_w[r+1]),
      .blk_o   (blk_w[r+1])
    );
  end

  md5sm_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_w[NR]),
    .st_i     (st_w[NR]),
    .blk_i    (blk_w[NR]),
    .target_i (target_q),
    .en_o     (pipe_en),
    .res_o    (res_o)
  );

endmodule

// ===== rtl/md5sm_round_cell.sv =====
// One MD5 round cell: applies one step to the state and hands it on.
// Depends on md5sm_pkg.
module md5sm_round_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        round_i,
  input  logic              en_i,
  input  logic              valid_i,
  input  md5sm_pkg::state_t st_i,
  input  md5sm_pkg::blk_t   blk_i,
  output logic              valid_o,
  output md5sm_pkg::state_t st_o,
  output md5sm_pkg::blk_t   blk_o
);

  logic [31:0]       f;
  logic [3:0]        g;
  logic [31:0]       wg;
  logic [31:0]       sum;
  logic [31:0]       rot;
  md5sm_pkg::state_t st_d;
  logic              valid_q;
  md5sm_pkg::state_t st_q;
  md5sm_pkg::blk_t   blk_q;

  always_comb begin
    f = md5sm_pkg::round_f(round_i[5:4], st_i.b, st_i.c, st_i.d);
    g = md5sm_pkg::msg_index(round_i);
    // Only words 0, 1 and 14 of the block can be nonzero.
    case (g)
      4'd0:    wg = blk_i.w0;
      4'd1:    wg = {24'd0, blk_i.pad1, 7'd0};
      4'd14:   wg = {26'd0, blk_i.bitlen};
      default: wg = 32'd0;
    endcase
    sum    = st_i.a + f + md5sm_pkg::SINE_K[round_i] + wg;
    rot    = md5sm_pkg::rotl(sum, md5sm_pkg::round_shift(round_i));
    st_d.a = st_i.d;
    st_d.b = st_i.b + rot;
    st_d.c = st_i.b;
    st_d.d = st_i.c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      blk_q <= blk_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign blk_o   = blk_q;

endmodule

// ===== rtl/md5sm_out_stage.sv =====
// Digest finish (add initial state, compare with target), output register and skid.
// Depends on md5sm_pkg and md5sm_res_if.
module md5sm_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  md5sm_pkg::state_t st_i,
  input  md5sm_pkg::blk_t   blk_i,
  input  md5sm_pkg::state_t target_i,
  output logic              en_o,
  md5sm_res_if.source       res_o
);

  logic              fin_valid_q;
  md5sm_pkg::res_t   fin_q;
  md5sm_pkg::res_t   fin_d;
  logic              out_valid_q;
  md5sm_pkg::res_t   out_q;
  logic              skid_valid_q;
  md5sm_pkg::res_t   skid_q;
  logic              en;
  logic              take;
  logic              out_free;

  assign en       = !skid_valid_q;
  assign take     = en && fin_valid_q;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    fin_d.match = ((st_i.a + md5sm_pkg::IV_A) == target_i.a) &&
                  ((st_i.b + md5sm_pkg::IV_B) == target_i.b) &&
                  ((st_i.c + md5sm_pkg::IV_C) == target_i.c) &&
                  ((st_i.d + md5sm_pkg::IV_D) == target_i.d);
    fin_d.cand  = blk_i.cand;
    fin_d.eor   = blk_i.eor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        fin_valid_q <= valid_i;
      end
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= take;
        end
      end else if (take) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (take) begin
        out_q <= fin_q;
      end
    end else if (take) begin
      skid_q <= fin_q;
    end
  end

  assign en_o                 = en;
  assign res_o.valid          = out_valid_q;
  assign res_o.match          = out_q.match;
  assign res_o.candidate_echo = out_q.cand;
  assign res_o.range_done     = out_q.eor;

  // The skid only fills behind a held output.
  skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output register is empty");

  skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !res_o.ready && fin_valid_q))
    else $error("skid filled without a stalled output");

  take_into_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("finished item lost on its way to an empty output");

endmodule

// ===== tb/md5_short_message_match_test.sv =====
// Self-checking testbench for md5_short_message_match: one-block MD5 of each candidate,
// compared with the target registers, checked against an in-bench digest calculation.
// Depends on md5sm_pkg, md5sm_in_if, md5sm_res_if and the md5_short_message_match RTL.
module md5_short_message_match_test;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_GAP        = 17;
  localparam int DRAIN_CYCLES   = 80;       // longer than the pipeline
  localparam int HOLD_CYCLES    = 300;      // long result-side hold, longer than the pipeline can absorb
  localparam int TIMEOUT_CYCLES = 300_000;
  localparam int MAX_REPORTS    = 100;

  // Register index that maps to nothing; writes there must be dropped.
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  localparam logic [2:0] TARGET_REG [4] = '{
    md5sm_pkg::REG_TARGET_A, md5sm_pkg::REG_TARGET_B,
    md5sm_pkg::REG_TARGET_C, md5sm_pkg::REG_TARGET_D
  };

  // Digest words A..D, index 0 is A.
  typedef logic [0:3][31:0] digest_t;

  localparam digest_t MD5_INIT = {32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
  localparam logic [31:0] PAD_MARK = 32'h0000_0080;

  localparam logic [31:0] MD5_SINE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned MD5_ROT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Directed length sweep: raw register value and the candidate hashed under it.
  // The last entry writes all ones, i.e. length seven, which must act as four.
  localparam logic [31:0] SWEEP_LEN_WRITE [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 32'hFFFF_FFFF
  };
  localparam logic [31:0] SWEEP_CAND [6] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0061, 32'h0063_6261, 32'h6463_6261, 32'h8000_0001
  };

  // Message length used in each random phase; every register value 0..7 shows up.
  localparam logic [2:0] PHASE_LEN [9] = '{
    3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4
  };
  localparam int PHASE_ITEMS = 34;

  logic clk;
  logic rst_n;

  md5sm_in_if  cand_if ();
  md5sm_res_if res_if ();

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  md5_short_message_match i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cand_i  (cand_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the configuration registers, updated on every completed write.
  digest_t    target_words = '0;
  logic [2:0] msg_len_reg  = md5sm_pkg::MSG_LEN_FULL;

  // Verdicts for accepted candidates, oldest first.
  md5sm_pkg::res_t expected_verdicts [$];
  md5sm_pkg::res_t oldest_verdict;

  int unsigned mismatch_count = 0;

  // Idling controls shared by the stimulus and the result receiver.
  bit          sender_gaps     = 1'b1;
  bit          receiver_gaps   = 1'b1;
  int unsigned hold_cycles_req = 0;

  always begin
    clk = 1'b1;
    #(CLK_PERIOD / 2);
    clk = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // One padded block: message bytes, the pad mark right behind them, bit length in
  // word 14. Register values above four act as four; zero hashes the empty message.
  function automatic digest_t md5_digest(input logic [31:0] cand, input logic [2:0] len_reg);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, mix, old_d;
    int unsigned nbytes, g, s;
    digest_t dg;
    nbytes = (len_reg > 3'd4) ? 4 : len_reg;
    for (int j = 0; j < 16; j++) w[j] = '0;
    if (nbytes == 4) begin
      w[0] = cand;
      w[1] = PAD_MARK;
    end else begin
      w[0] = (cand & ((32'd1 << (8 * nbytes)) - 32'd1)) | (PAD_MARK << (8 * nbytes));
    end
    w[14] = 8 * nbytes;
    a = MD5_INIT[0];
    b = MD5_INIT[1];
    c = MD5_INIT[2];
    d = MD5_INIT[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = MD5_ROT[4 * (i / 16) + i % 4];
      mix = a + f + MD5_SINE[i] + w[g];
      old_d = d;
      d = c;
      c = b;
      b = b + ((mix << s) | (mix >> (32 - s)));
      a = old_d;
    end
    dg[0] = a + MD5_INIT[0];
    dg[1] = b + MD5_INIT[1];
    dg[2] = c + MD5_INIT[2];
    dg[3] = d + MD5_INIT[3];
    return dg;
  endfunction

  task automatic report_mismatch(input string what);
    // Cap the printout so a badly broken block cannot flood the log; keep counting.
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // APB write: setup phase, access phase until pready, then an idle step so that
  // back-to-back writes never assign psel twice in one step. Enter and leave on a rising edge.
  task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      md5sm_pkg::REG_TARGET_A: target_words[0] = value;
      md5sm_pkg::REG_TARGET_B: target_words[1] = value;
      md5sm_pkg::REG_TARGET_C: target_words[2] = value;
      md5sm_pkg::REG_TARGET_D: target_words[3] = value;
      md5sm_pkg::REG_MSG_LEN:  msg_len_reg     = value[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_targets(input digest_t goal);
    for (int k = 0; k < 4; k++) apb_write(TARGET_REG[k], goal[k]);
  endtask

  // Offer one candidate after a random gap and hold it until accepted; queue the
  // verdict worked out under the current configuration.
  task automatic send_candidate(input logic [31:0] cand, input logic eor);
    int unsigned gap;
    md5sm_pkg::res_t verdict;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      cand_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_if.valid          <= 1'b1;
    cand_if.candidate_word <= cand;
    cand_if.end_of_range   <= eor;
    do @(posedge clk); while (!cand_if.ready);
    verdict.match = (md5_digest(cand, msg_len_reg) == target_words);
    verdict.cand  = cand;
    verdict.eor   = eor;
    expected_verdicts.push_back(verdict);
  endtask

  // Drop valid and hold off until every queued verdict has been matched by a result.
  // Always advance past a clock edge so a following send starts in a fresh step.
  task automatic wait_drained();
    cand_if.valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  // Reset values: all-zero targets never match, length four hashes the full word.
  task automatic test_reset_defaults();
    send_candidate(32'h0000_0000, 1'b0);
    send_candidate(32'hFFFF_FFFF, 1'b1);
  endtask

  // For each length: the exact candidate matches, a change in the top byte matches
  // only when that byte is outside the message, a change in bit 0 matches only for
  // the empty message. Covers zero length, pad placement and saturation above four.
  task automatic test_message_lengths();
    for (int n = 0; n < 6; n++) begin
      wait_drained();
      apb_write(md5sm_pkg::REG_MSG_LEN, SWEEP_LEN_WRITE[n]);
      set_targets(md5_digest(SWEEP_CAND[n], msg_len_reg));
      send_candidate(SWEEP_CAND[n], 1'b1);
      send_candidate(SWEEP_CAND[n] ^ 32'hFF00_0000, 1'b0);
      send_candidate(SWEEP_CAND[n] ^ 32'h0000_0001, 1'b1);
    end
  endtask

  // Bend one bit of one target word at a time: the match must drop each time.
  // Then write an unmapped address, which must leave the targets alone.
  task automatic test_target_near_miss();
    digest_t goal;
    logic [31:0] cand;
    cand = 32'h5A5A_A5A5;
    wait_drained();
    goal = md5_digest(cand, msg_len_reg);
    set_targets(goal);
    for (int k = 0; k < 4; k++) begin
      wait_drained();
      apb_write(TARGET_REG[k], goal[k] ^ (32'd1 << $urandom_range(0, 31)));
      send_candidate(cand, 1'b0);
      wait_drained();
      apb_write(TARGET_REG[k], goal[k]);
    end
    apb_write(REG_UNMAPPED, $urandom());
    send_candidate(cand, 1'b1);
  endtask

  // Phases of random traffic. Each phase picks a length, a hidden candidate and sets
  // the targets to its digest (one phase uses random targets), then mixes the hidden
  // candidate, variants in the ignored bytes, one-bit neighbors and pure noise.
  task automatic test_random_traffic();
    logic [31:0] secret, ignored, cand;
    int unsigned nbytes;
    for (int p = 0; p < 9; p++) begin
      wait_drained();
      // Rotate idling: both sides, receiver only, sender only, none.
      sender_gaps   = (p % 4 == 0) || (p % 4 == 2);
      receiver_gaps = (p % 4 == 0) || (p % 4 == 1);
      apb_write(md5sm_pkg::REG_MSG_LEN, ($urandom() & 32'hFFFF_FFF8) | PHASE_LEN[p]);
      secret = $urandom();
      if (p == 5) begin
        set_targets({$urandom(), $urandom(), $urandom(), $urandom()});
      end else begin
        set_targets(md5_digest(secret, msg_len_reg));
      end
      nbytes  = (msg_len_reg > 3'd4) ? 4 : msg_len_reg;
      ignored = (nbytes == 4) ? 32'h0 : ~((32'd1 << (8 * nbytes)) - 32'd1);
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 7))
          0, 1: cand = secret ^ ($urandom() & ignored);
          2:    cand = secret ^ (32'd1 << $urandom_range(0, 31));
          default: cand = $urandom();
        endcase
        send_candidate(cand, $urandom_range(0, 7) == 0);
      end
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // Hold the result side for a long stretch while candidates keep coming back to back,
  // so the round chain fills and the input stalls; then release and drain.
  task automatic test_output_backpressure();
    logic [31:0] secret;
    wait_drained();
    secret = $urandom();
    apb_write(md5sm_pkg::REG_MSG_LEN, 32'h0000_0004);
    set_targets(md5_digest(secret, msg_len_reg));
    sender_gaps     = 1'b0;
    receiver_gaps   = 1'b0;
    hold_cycles_req = HOLD_CYCLES;
    repeat (120) send_candidate(($urandom_range(0, 3) == 0) ? secret : $urandom(),
                                $urandom_range(0, 1));
    wait_drained();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // Result receiver: draw a stall before each item, or take a long hold on request.
  initial begin : result_receiver
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles_req != 0) begin
        stall = hold_cycles_req;
        hold_cycles_req = 0;
      end else if (receiver_gaps) begin
        stall = $urandom_range(0, MAX_GAP);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Compare every accepted result with the oldest queued verdict, field by field.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, candidate %h",
                                  res_if.candidate_echo));
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        if (res_if.match !== oldest_verdict.match)
          report_mismatch($sformatf("match %b, want %b for candidate %h", res_if.match,
                                    oldest_verdict.match, oldest_verdict.cand));
        if (res_if.candidate_echo !== oldest_verdict.cand)
          report_mismatch($sformatf("candidate_echo %h, want %h", res_if.candidate_echo,
                                    oldest_verdict.cand));
        if (res_if.range_done !== oldest_verdict.eor)
          report_mismatch($sformatf("range_done %b, want %b for candidate %h",
                                    res_if.range_done, oldest_verdict.eor,
                                    oldest_verdict.cand));
      end
    end
  end

  // Hard stop in case the block hangs or loses results.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n                  = 1'b0;
    cand_if.valid          = 1'b0;
    cand_if.candidate_word = '0;
    cand_if.end_of_range   = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_message_lengths();
    test_target_near_miss();
    test_random_traffic();
    test_output_backpressure();

    // Let the pipeline run dry and watch for stray results.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
